[rtl/core/pfa_pkg.sv]
// ============================================================================
// Packed field array package
// Shared widths, operation and status codes, channel payloads and the
// control bundles that pass between the sequencer, the word memory and the
// top level.
// ============================================================================
package pfa_pkg;

   // Storage geometry.
   localparam int unsigned WORD_BITS       = 64;
   localparam int unsigned BLOCK_WORDS_DEF = 32;
   localparam int unsigned COUNT_LIMIT     = 4094;

   // Field widths.
   localparam int unsigned MODE_W   = 2;
   localparam int unsigned INDEX_W  = 12;
   localparam int unsigned VALUE_W  = 64;
   localparam int unsigned WIDTH_W  = 7;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned COUNT_W  = 12;

   // A bit position is index times width; its upper bits name a word.
   localparam int unsigned BITPOS_W = 19;
   localparam int unsigned SHAMT_W  = 6;
   localparam int unsigned WADDR_W  = BITPOS_W - SHAMT_W;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd8;

   // Operation codes.
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd2;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd3;

   // Status codes.
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  read_value;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  element_count;
   } rsp_payload_type;

   // Width register update as seen by the sequencer.
   typedef struct packed {
      logic               update;
      logic [COUNT_W-1:0] cap_new;
   } cfg_type;

   // One read and one write per cycle into the word memory.
   typedef struct packed {
      logic                 rd_en;
      logic [WADDR_W-1:0]   rd_addr;
      logic                 wr_en;
      logic [WADDR_W-1:0]   wr_addr;
      logic [WORD_BITS-1:0] wr_data;
   } ram_cmd_type;

endpackage

[rtl/core/pfa_stream_if.sv]
// ============================================================================
// Packed field array stream channel
// Valid and ready handshake with a typed payload; a word moves at a rising
// edge where both are high.
// ============================================================================
interface pfa_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

[rtl/core/pfa_word_ram.sv]
// ============================================================================
// Packed field array word memory
// Synchronous memory with one write and one registered read per cycle.
// ============================================================================
module pfa_word_ram #(
   parameter int unsigned DEPTH  = pfa_pkg::BLOCK_WORDS_DEF,
   parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic                           clock,
   input  pfa_pkg::ram_cmd_type           cmd,
   output logic [pfa_pkg::WORD_BITS-1:0]  rd_data
);

   logic [pfa_pkg::WORD_BITS-1:0] mem_ff [DEPTH];
   logic [pfa_pkg::WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[cmd.wr_addr[ADDR_W-1:0]] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[cmd.rd_addr[ADDR_W-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/pfa_seq.sv]
// ============================================================================
// Packed field array sequencer
// Decodes a request, walks the word memory to move elements for insert and
// delete, performs the element read or merge, and holds the response.
// ============================================================================
module pfa_seq #(
   parameter int unsigned BLOCK_WORDS = pfa_pkg::BLOCK_WORDS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pfa_pkg::WIDTH_W-1:0]   width,
   input  logic [pfa_pkg::COUNT_W-1:0]   capacity,
   input  pfa_pkg::cfg_type              cfg,
   pfa_stream_if.sink                    req_chan,
   pfa_stream_if.source                  rsp_chan,
   output pfa_pkg::ram_cmd_type          ram_cmd,
   input  logic [pfa_pkg::WORD_BITS-1:0] ram_rdata
);

   localparam int unsigned AW = pfa_pkg::WADDR_W;
   localparam int unsigned PW = pfa_pkg::BITPOS_W;
   localparam int unsigned CW = pfa_pkg::COUNT_W;
   localparam int unsigned DW = pfa_pkg::WORD_BITS;
   localparam int unsigned SW = pfa_pkg::SHAMT_W;
   localparam int unsigned WW = pfa_pkg::WIDTH_W;
   localparam logic [AW-1:0] DEPTH_A = AW'(BLOCK_WORDS);
   localparam logic [SW-1:0] BIT_TOP = SW'(DW - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SH_START,
      S_SH_PRIME,
      S_SH_RUN,
      S_EL_RD0,
      S_EL_RD1,
      S_EL_EXEC,
      S_EL_WR1,
      S_RESP
   } state_type;

   state_type                        state_ff, state_in;
   logic [pfa_pkg::MODE_W-1:0]       mode_ff, mode_in;
   logic [pfa_pkg::INDEX_W-1:0]      index_ff, index_in;
   logic [DW-1:0]                    value_ff, value_in;
   logic [CW-1:0]                    count_ff, count_in;
   logic [pfa_pkg::STATUS_W-1:0]     status_ff, status_in;
   logic [PW-1:0]                    lo_ff, lo_in;
   logic [PW-1:0]                    hi_ff, hi_in;
   logic [AW-1:0]                    cur_ff, cur_in;
   logic [AW-1:0]                    end_ff, end_in;
   logic [AW-1:0]                    lo_word_ff, lo_word_in;
   logic [AW-1:0]                    hi_word_ff, hi_word_in;
   logic [SW-1:0]                    lo_bit_ff, lo_bit_in;
   logic [SW-1:0]                    hi_bit_ff, hi_bit_in;
   logic                             up_ff, up_in;
   logic [DW-1:0]                    hold_ff, hold_in;
   logic                             rzero_ff, rzero_in;
   logic [DW-1:0]                    rd_value_ff, rd_value_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   pfa_pkg::rsp_payload_type         rsp_ff, rsp_in;

   logic [DW-1:0]     rword;
   logic [PW-1:0]     pos_lo;
   logic [PW-1:0]     pos_hi;
   logic [CW-1:0]     n_adj;
   logic [PW-1:0]     hi_last;
   logic              up_now;
   logic [AW-1:0]     el_word;
   logic [AW-1:0]     nb1;
   logic [AW-1:0]     nb2;
   logic [DW-1:0]     ones;
   logic [DW-1:0]     elem_mask;
   logic [2*DW-1:0]   sh_cat;
   logic [WW-1:0]     sh_amt;
   logic [DW-1:0]     shifted;
   logic [DW-1:0]     lo_mask;
   logic [DW-1:0]     hi_mask;
   logic [DW-1:0]     word_mask;
   logic [DW-1:0]     sh_word;
   logic [2*DW-1:0]   el_cat;
   logic [DW-1:0]     el_read;
   logic [2*DW-1:0]   el_new;
   logic [CW-1:0]     count_done;
   logic              rd_req;
   logic [AW-1:0]     rd_a;
   logic              wr_req;
   logic [AW-1:0]     wr_a;
   logic [DW-1:0]     wr_d;

   // Reads past the end of the memory return zero.
   assign rword = rzero_ff ? '0 : ram_rdata;

   // Bit bounds of the target element and of the moved region.
   assign pos_lo  = PW'(index_ff) * PW'(width);
   assign n_adj   = (mode_ff == pfa_pkg::MODE_INSERT) ? count_ff + CW'(1) : count_ff - CW'(1);
   assign pos_hi  = PW'(n_adj) * PW'(width);
   assign hi_last = hi_ff - PW'(1);
   assign up_now  = (mode_ff == pfa_pkg::MODE_DELETE);
   assign el_word = lo_ff[PW-1:SW];

   assign nb1 = up_ff ? cur_ff + AW'(1) : cur_ff - AW'(1);
   assign nb2 = up_ff ? cur_ff + AW'(2) : cur_ff - AW'(2);

   assign ones      = '1;
   assign elem_mask = ~(ones << width);

   // Word move: delete pulls bits down from the next word, insert pushes
   // bits up from the previous word.
   assign sh_cat    = up_ff ? {rword, hold_ff} : {hold_ff, rword};
   assign sh_amt    = up_ff ? width : WW'(DW) - width;
   assign shifted   = DW'(sh_cat >> sh_amt);
   assign lo_mask   = (cur_ff == lo_word_ff) ? (ones << lo_bit_ff) : ones;
   assign hi_mask   = (cur_ff == hi_word_ff) ? (ones >> (BIT_TOP - hi_bit_ff)) : ones;
   assign word_mask = lo_mask & hi_mask;
   assign sh_word   = (hold_ff & ~word_mask) | (shifted & word_mask);

   // Element access over the word pair that may hold a straddling element.
   assign el_cat  = {rword, hold_ff};
   assign el_read = DW'(el_cat >> lo_ff[SW-1:0]) & elem_mask;
   assign el_new  = (el_cat & ~({{DW{1'b0}}, elem_mask} << lo_ff[SW-1:0]))
                  | ({{DW{1'b0}}, value_ff & elem_mask} << lo_ff[SW-1:0]);

   always_comb begin
      count_done = count_ff;
      if (status_ff == pfa_pkg::STAT_OK) begin
         if (mode_ff == pfa_pkg::MODE_INSERT) begin
            count_done = count_ff + CW'(1);
         end else if (mode_ff == pfa_pkg::MODE_DELETE) begin
            count_done = count_ff - CW'(1);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      index_in     = index_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      cur_in       = cur_ff;
      end_in       = end_ff;
      lo_word_in   = lo_word_ff;
      hi_word_in   = hi_word_ff;
      lo_bit_in    = lo_bit_ff;
      hi_bit_in    = hi_bit_ff;
      up_in        = up_ff;
      hold_in      = hold_ff;
      rd_value_in  = rd_value_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_req       = 1'b0;
      rd_a         = '0;
      wr_req       = 1'b0;
      wr_a         = '0;
      wr_d         = '0;

      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // A narrower width can leave fewer places than elements held.
      if (cfg.update && (count_ff > cfg.cap_new)) begin
         count_in = cfg.cap_new;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               mode_in  = req_chan.payload.mode;
               index_in = req_chan.payload.index;
               value_in = req_chan.payload.value;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            lo_in     = pos_lo;
            hi_in     = pos_hi;
            status_in = pfa_pkg::STAT_OK;
            unique case (mode_ff)
               pfa_pkg::MODE_READ, pfa_pkg::MODE_WRITE: begin
                  if (CW'(index_ff) >= count_ff) begin
                     status_in = pfa_pkg::STAT_RANGE;
                  end
               end
               pfa_pkg::MODE_INSERT: begin
                  priority if (CW'(index_ff) > count_ff) begin
                     status_in = pfa_pkg::STAT_RANGE;
                  end else if (count_ff >= capacity) begin
                     status_in = pfa_pkg::STAT_FULL;
                  end else begin
                     status_in = pfa_pkg::STAT_OK;
                  end
               end
               pfa_pkg::MODE_DELETE: begin
                  priority if (count_ff == '0) begin
                     status_in = pfa_pkg::STAT_EMPTY;
                  end else if (CW'(index_ff) >= count_ff) begin
                     status_in = pfa_pkg::STAT_RANGE;
                  end else begin
                     status_in = pfa_pkg::STAT_OK;
                  end
               end
            endcase
            if (status_in != pfa_pkg::STAT_OK) begin
               state_in = S_RESP;
            end else if (mode_ff == pfa_pkg::MODE_READ || mode_ff == pfa_pkg::MODE_WRITE) begin
               state_in = S_EL_RD0;
            end else begin
               state_in = S_SH_START;
            end
         end

         S_SH_START: begin
            lo_word_in = lo_ff[PW-1:SW];
            hi_word_in = hi_last[PW-1:SW];
            lo_bit_in  = lo_ff[SW-1:0];
            hi_bit_in  = hi_last[SW-1:0];
            up_in      = up_now;
            if (up_now && (hi_ff <= lo_ff)) begin
               // Deleting the last element moves nothing.
               state_in = S_RESP;
            end else begin
               cur_in   = up_now ? lo_ff[PW-1:SW] : hi_last[PW-1:SW];
               end_in   = up_now ? hi_last[PW-1:SW] : lo_ff[PW-1:SW];
               rd_req   = 1'b1;
               rd_a     = cur_in;
               state_in = S_SH_PRIME;
            end
         end

         S_SH_PRIME: begin
            hold_in  = rword;
            rd_req   = 1'b1;
            rd_a     = nb1;
            state_in = S_SH_RUN;
         end

         S_SH_RUN: begin
            wr_req  = 1'b1;
            wr_a    = cur_ff;
            wr_d    = sh_word;
            hold_in = rword;
            if (cur_ff == end_ff) begin
               state_in = up_ff ? S_RESP : S_EL_RD0;
            end else begin
               cur_in = nb1;
               rd_req = 1'b1;
               rd_a   = nb2;
            end
         end

         S_EL_RD0: begin
            rd_req   = 1'b1;
            rd_a     = el_word;
            state_in = S_EL_RD1;
         end

         S_EL_RD1: begin
            hold_in  = rword;
            rd_req   = 1'b1;
            rd_a     = el_word + AW'(1);
            state_in = S_EL_EXEC;
         end

         S_EL_EXEC: begin
            if (mode_ff == pfa_pkg::MODE_READ) begin
               rd_value_in = el_read;
               state_in    = S_RESP;
            end else begin
               wr_req   = 1'b1;
               wr_a     = el_word;
               wr_d     = el_new[DW-1:0];
               hold_in  = el_new[2*DW-1:DW];
               state_in = S_EL_WR1;
            end
         end

         S_EL_WR1: begin
            wr_req   = 1'b1;
            wr_a     = el_word + AW'(1);
            wr_d     = hold_ff;
            state_in = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.read_value    = (mode_ff == pfa_pkg::MODE_READ &&
                                       status_ff == pfa_pkg::STAT_OK) ? rd_value_ff : '0;
               rsp_in.status        = status_ff;
               rsp_in.element_count = count_done;
               count_in             = count_done;
               state_in             = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Accesses past the last word are dropped; their reads come back as zero.
   always_comb begin
      ram_cmd         = '0;
      ram_cmd.rd_en   = rd_req && (rd_a < DEPTH_A);
      ram_cmd.rd_addr = rd_a;
      ram_cmd.wr_en   = wr_req && (wr_a < DEPTH_A);
      ram_cmd.wr_addr = wr_a;
      ram_cmd.wr_data = wr_d;
      rzero_in        = rd_req ? !(rd_a < DEPTH_A) : rzero_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      index_ff    <= index_in;
      value_ff    <= value_in;
      status_ff   <= status_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      cur_ff      <= cur_in;
      end_ff      <= end_in;
      lo_word_ff  <= lo_word_in;
      hi_word_ff  <= hi_word_in;
      lo_bit_ff   <= lo_bit_in;
      hi_bit_ff   <= hi_bit_in;
      up_ff       <= up_in;
      hold_ff     <= hold_in;
      rzero_ff    <= rzero_in;
      rd_value_ff <= rd_value_in;
      rsp_ff      <= rsp_in;
   end

   assign req_chan.ready  = (state_ff == S_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

endmodule

[rtl/core/packed_field_array_insert_delete.sv]
// A request passes through decode; an insert or delete then moves every memory word from the target
// element to the end of the stored data (none when a delete removes the last element); a read, write
// or insert then accesses the element before the response. A rejected request goes straight to it.
// One request is in flight at a time; the next can be taken from the cycle its response turns valid.
// The moved words are bounded by BLOCK_WORDS, the memory depth; a move writes one word per cycle.
// Reset clears the element count and sets the width to 8; the word memory is not cleared.
// ============================================================================
// Packed field array with insert and delete
// Stores elements of a configurable bit width packed back to back in a word
// memory, with read, overwrite, insert and delete at an element index.
// ============================================================================
module packed_field_array_insert_delete #(
   parameter int unsigned BLOCK_WORDS = pfa_pkg::BLOCK_WORDS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [pfa_pkg::WIDTH_W-1:0] csr_wdata,
   pfa_stream_if.sink                  req_chan,
   pfa_stream_if.source                rsp_chan
);

   localparam int unsigned ADDR_W = $clog2(BLOCK_WORDS);
   localparam int unsigned CW     = pfa_pkg::COUNT_W;
   localparam int unsigned WW     = pfa_pkg::WIDTH_W;
   localparam int unsigned SW     = pfa_pkg::SHAMT_W;
   localparam int unsigned NWIDTH = pfa_pkg::WORD_BITS;

   // Capacity for every legal width, worked out at elaboration. Entry k
   // holds the capacity for a width of k + 1 bits: the bit budget divided by
   // the width, rounded down to an even count and capped so it fits the
   // element counter.
   logic [CW-1:0] cap_table [NWIDTH];

   for (genvar g = 0; g < NWIDTH; g++) begin : g_cap
      localparam int unsigned RAW_CAP  = (BLOCK_WORDS * pfa_pkg::WORD_BITS) / (g + 1);
      localparam int unsigned EVEN_CAP = (RAW_CAP / 2) * 2;
      localparam int unsigned CAP      = (EVEN_CAP > pfa_pkg::COUNT_LIMIT) ?
                                         pfa_pkg::COUNT_LIMIT : EVEN_CAP;
      assign cap_table[g] = CW'(CAP);
   end

   // The width register holds the effective width. A written zero acts as
   // one bit and anything above a full word acts as a full word, so every
   // later computation sees a width from 1 to 64.
   logic [WW-1:0]         new_width;
   logic [WW-1:0]         new_width_m1;
   logic [CW-1:0]         cap_new;
   logic [WW-1:0]         width_ff, width_in;
   logic [CW-1:0]         cap_ff, cap_in;
   pfa_pkg::cfg_type      cfg;
   pfa_pkg::ram_cmd_type  ram_cmd;
   logic [pfa_pkg::WORD_BITS-1:0] ram_rdata;

   always_comb begin
      priority if (csr_wdata == '0) begin
         new_width = WW'(1);
      end else if (csr_wdata > WW'(NWIDTH)) begin
         new_width = WW'(NWIDTH);
      end else begin
         new_width = csr_wdata;
      end
   end

   assign new_width_m1 = new_width - WW'(1);
   assign cap_new      = cap_table[new_width_m1[SW-1:0]];

   always_comb begin
      width_in = width_ff;
      cap_in   = cap_ff;
      if (csr_we) begin
         width_in = new_width;
         cap_in   = cap_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= pfa_pkg::WIDTH_RESET;
         cap_ff   <= cap_table[SW'(pfa_pkg::WIDTH_RESET - WW'(1))];
      end else begin
         width_ff <= width_in;
         cap_ff   <= cap_in;
      end
   end

   // The sequencer trims the element count in the same cycle as the width
   // write, using the capacity of the new width.
   assign cfg = '{update: csr_we, cap_new: cap_new};

   // The sequencer owns the request and response channels and the element
   // count; every access to the stored words goes through the memory below.
   pfa_seq #(
      .BLOCK_WORDS (BLOCK_WORDS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .width     (width_ff),
      .capacity  (cap_ff),
      .cfg       (cfg),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .ram_cmd   (ram_cmd),
      .ram_rdata (ram_rdata)
   );

   // Word store: one read and one write per cycle, with registered read data.
   pfa_word_ram #(
      .DEPTH  (BLOCK_WORDS),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .cmd     (ram_cmd),
      .rd_data (ram_rdata)
   );

   // Only one request is worked on at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while another one is in flight");

   // The count never passes the largest capacity.
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.payload.element_count <= CW'(pfa_pkg::COUNT_LIMIT)))
      else $error("element count above its limit");

   // Only a successful read returns data.
   a_read_value_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.payload.read_value != '0))
      |-> (rsp_chan.payload.status == pfa_pkg::STAT_OK))
      else $error("nonzero read value on a failed request");

   // An empty status goes with an empty store.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.payload.status == pfa_pkg::STAT_EMPTY))
      |-> (rsp_chan.payload.element_count == '0))
      else $error("empty status with elements stored");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ============================================================================
// Packed field array insert and delete testbench
// Drives read, write, insert and delete requests at many element widths with
// random idling on both channels. A shadow copy of the memory words and the
// element count predicts every response, which is checked field by field.
// ============================================================================
module tb_top;
   import pfa_pkg::*;

   localparam int unsigned MEM_WORDS    = BLOCK_WORDS_DEF;
   localparam int unsigned TOTAL_BITS   = MEM_WORDS * WORD_BITS;
   localparam int unsigned CYCLE_LIMIT  = 600000;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned MAX_REPORTS  = 10;
   localparam int unsigned PHASE_COUNT  = 12;
   localparam int unsigned PHASE_ITEMS  = 165;
   localparam int unsigned CALM_ITEMS   = 100;
   localparam int unsigned RUN_LENGTH   = 40;
   localparam int unsigned FLUSH_CYCLES = 60;

   // A request together with the response the shadow copy predicts for it.
   typedef struct {
      req_payload_type req;
      rsp_payload_type rsp;
   } op_record_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_we;
   logic [WIDTH_W-1:0] csr_wdata;

   pfa_stream_if #(.payload_type(req_payload_type)) req_if ();
   pfa_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   packed_field_array_insert_delete #(.BLOCK_WORDS(MEM_WORDS)) DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_if.sink),
      .rsp_chan  (rsp_if.source)
   );

   // Requests not yet taken by the block, and responses still owed by it.
   op_record_type pending_requests [$];
   op_record_type awaited_responses [$];

   // Shadow copy of the block state. Only the stimulus process writes it.
   logic [WORD_BITS-1:0] shadow_words [MEM_WORDS];
   logic [COUNT_W-1:0]   shadow_count;
   logic [WIDTH_W-1:0]   shadow_width_reg;

   int unsigned mismatch_count = 0;
   int unsigned hold_requests  = 0;
   bit          req_taken      = 1'b0;
   bit          calm           = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 0;
   end

   // ------------------------------------------------------------------------
   // Shadow copy of the block.
   // ------------------------------------------------------------------------

   // A width register of zero behaves as one, anything above 64 as 64.
   function automatic int unsigned field_width();
      if (shadow_width_reg == '0) return 1;
      if (shadow_width_reg > WORD_BITS) return WORD_BITS;
      return shadow_width_reg;
   endfunction

   // Elements that fit the memory, rounded down to an even number and capped at COUNT_LIMIT.
   function automatic int unsigned element_capacity();
      int unsigned cap;
      cap = (TOTAL_BITS / field_width() / 2) * 2;
      return (cap > COUNT_LIMIT) ? COUNT_LIMIT : cap;
   endfunction

   function automatic logic [WORD_BITS-1:0] field_mask();
      if (field_width() >= WORD_BITS) return '1;
      return (64'd1 << field_width()) - 64'd1;
   endfunction

   // An element may straddle two memory words, so both are joined into one
   // double word and the element is cut out at its bit offset.
   function automatic logic [WORD_BITS-1:0] fetch_element(input int unsigned pos);
      int unsigned            bitpos, q, r;
      logic [2*WORD_BITS-1:0] pair;
      bitpos = pos * field_width();
      q = bitpos / WORD_BITS;
      r = bitpos % WORD_BITS;
      pair[WORD_BITS-1:0]           = (q < MEM_WORDS) ? shadow_words[q] : '0;
      pair[2*WORD_BITS-1:WORD_BITS] = (q + 1 < MEM_WORDS) ? shadow_words[q+1] : '0;
      pair = pair >> r;
      return pair[WORD_BITS-1:0] & field_mask();
   endfunction

   function automatic void store_element(input int unsigned pos,
                                         input logic [WORD_BITS-1:0] val);
      int unsigned            bitpos, q, r;
      logic [2*WORD_BITS-1:0] pair, keep_mask;
      bitpos = pos * field_width();
      q = bitpos / WORD_BITS;
      r = bitpos % WORD_BITS;
      pair[WORD_BITS-1:0]           = (q < MEM_WORDS) ? shadow_words[q] : '0;
      pair[2*WORD_BITS-1:WORD_BITS] = (q + 1 < MEM_WORDS) ? shadow_words[q+1] : '0;
      keep_mask = {{WORD_BITS{1'b0}}, field_mask()} << r;
      pair = (pair & ~keep_mask) | ({{WORD_BITS{1'b0}}, val & field_mask()} << r);
      if (q < MEM_WORDS) shadow_words[q] = pair[WORD_BITS-1:0];
      if (q + 1 < MEM_WORDS) shadow_words[q+1] = pair[2*WORD_BITS-1:WORD_BITS];
   endfunction

   function automatic rsp_payload_type predict_response(input req_payload_type req);
      rsp_payload_type rsp;
      int unsigned     n, idx, j;
      rsp = '0;
      rsp.status = STAT_OK;
      n = shadow_count;
      idx = req.index;
      case (req.mode)
         MODE_READ: begin
            if (idx >= n) rsp.status = STAT_RANGE;
            else rsp.read_value = fetch_element(idx);
         end
         MODE_WRITE: begin
            if (idx >= n) rsp.status = STAT_RANGE;
            else store_element(idx, req.value);
         end
         MODE_INSERT: begin
            if (idx > n) rsp.status = STAT_RANGE;
            else if (n >= element_capacity()) rsp.status = STAT_FULL;
            else begin
               // Open a gap at the index by moving the tail up one place.
               for (j = n; j > idx; j--) store_element(j, fetch_element(j - 1));
               store_element(idx, req.value);
               shadow_count = COUNT_W'(n + 1);
            end
         end
         default: begin
            // An empty store is reported ahead of a bad index.
            if (n == 0) rsp.status = STAT_EMPTY;
            else if (idx >= n) rsp.status = STAT_RANGE;
            else begin
               for (j = idx; j + 1 < n; j++) store_element(j, fetch_element(j + 1));
               shadow_count = COUNT_W'(n - 1);
            end
         end
      endcase
      rsp.element_count = shadow_count;
      return rsp;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------

   task automatic queue_request(input logic [MODE_W-1:0] mode,
                                input logic [INDEX_W-1:0] index,
                                input logic [VALUE_W-1:0] value);
      op_record_type entry;
      entry.req.mode  = mode;
      entry.req.index = index;
      entry.req.value = value;
      entry.rsp = predict_response(entry.req);
      pending_requests.push_back(entry);
   endtask

   // Blocks until every queued request has been answered and then lets
   // the block settle.
   task automatic wait_idle();
      while (pending_requests.size() != 0 || awaited_responses.size() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   // The width register is written only while the block is idle. A new
   // width reinterprets the stored bits and may cut the element count.
   task automatic program_width(input logic [WIDTH_W-1:0] new_width);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= new_width;
      @(negedge clock);
      csr_we    <= 1'b0;
      shadow_width_reg = new_width;
      if (shadow_count > element_capacity()) shadow_count = COUNT_W'(element_capacity());
      @(posedge clock);
   endtask

   // Mostly well-formed requests with indices inside the stored range, with
   // some landing just past the end and a few anywhere in the index space.
   // The growing flag tilts the mix toward inserts so that the store fills,
   // and its absence toward deletes so that it drains.
   task automatic random_request(input bit growing);
      int unsigned        n, pick, idx;
      logic [MODE_W-1:0]  mode;
      logic [VALUE_W-1:0] val;
      n = shadow_count;
      pick = $urandom_range(99);
      if (growing)
         mode = (pick < 45) ? MODE_INSERT : (pick < 60) ? MODE_DELETE :
                (pick < 80) ? MODE_READ : MODE_WRITE;
      else
         mode = (pick < 15) ? MODE_INSERT : (pick < 55) ? MODE_DELETE :
                (pick < 80) ? MODE_READ : MODE_WRITE;
      pick = $urandom_range(99);
      if (pick < 8) idx = $urandom_range(4095);
      else if (pick < 14) idx = n + $urandom_range(2);
      else if (pick < 24) idx = 0;
      else if (pick < 34) idx = (mode == MODE_INSERT) ? n : ((n > 0) ? n - 1 : 0);
      else if (mode == MODE_INSERT) idx = $urandom_range(n);
      else idx = (n > 0) ? $urandom_range(n - 1) : 0;
      pick = $urandom_range(9);
      if (pick == 0) val = '0;
      else if (pick == 1) val = '1;
      else val = {$urandom, $urandom};
      queue_request(mode, idx[INDEX_W-1:0], val);
   endtask

   // ------------------------------------------------------------------------
   // Stimulus sequence.
   // ------------------------------------------------------------------------
   initial begin
      int unsigned        k, p, phase_items;
      logic [WIDTH_W-1:0] next_width;
      logic [VALUE_W-1:0] fill_value;

      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;

      shadow_count     = '0;
      shadow_width_reg = WIDTH_RESET;
      for (k = 0; k < MEM_WORDS; k++) shadow_words[k] = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Every request on the empty store after reset fails, and none of
      // them touches the memory words.
      queue_request(MODE_READ,   '0, '1);
      queue_request(MODE_WRITE,  '0, '1);
      queue_request(MODE_DELETE, '0, '0);
      queue_request(MODE_DELETE, '1, '0);
      queue_request(MODE_INSERT, 12'd1, '1);
      queue_request(MODE_READ,   '1, '0);
      wait_idle();

      // The memory is not cleared by reset. At the full word width the
      // capacity is one element per memory word, so filling the store once
      // writes every bit and later width changes never expose unwritten bits.
      program_width(7'd64);
      for (k = 0; k < MEM_WORDS; k++) begin
         if (k == 0) fill_value = '0;
         else if (k == 1) fill_value = '1;
         else fill_value = {$urandom, $urandom};
         queue_request(MODE_INSERT, shadow_count, fill_value);
      end

      // Full store, indices at and past the end, and moves of the whole
      // memory in both directions.
      queue_request(MODE_INSERT, '0, '1);
      queue_request(MODE_INSERT, 12'd32, '1);
      queue_request(MODE_INSERT, 12'd33, '1);
      queue_request(MODE_READ,   '0, '0);
      queue_request(MODE_READ,   12'd31, '0);
      queue_request(MODE_READ,   12'd32, '0);
      queue_request(MODE_WRITE,  12'd31, '1);
      queue_request(MODE_DELETE, 12'd31, '0);
      queue_request(MODE_DELETE, '0, '0);
      queue_request(MODE_INSERT, '0, '0);

      // Random phases, each at its own width. The extremes come with the
      // out-of-range register values that fold back onto them.
      for (p = 0; p < PHASE_COUNT; p++) begin
         wait_idle();
         case (p)
            0:       next_width = 7'd1;
            1:       next_width = 7'd5;
            2:       next_width = 7'd127;
            3:       next_width = 7'd0;
            4:       next_width = 7'd13;
            5:       next_width = 7'd33;
            6:       next_width = 7'd2;
            7:       next_width = 7'd63;
            8, 9:    next_width = WIDTH_W'($urandom_range(64, 1));
            10:      next_width = 7'd64;
            default: next_width = 7'd8;
         endcase
         program_width(next_width);

         // The response side stalls for a long stretch while requests keep
         // coming, so the block holds a finished response and holds off its input.
         if (p == 2) hold_requests++;

         // The closing phase runs without idling on either side.
         if (p == PHASE_COUNT - 1) calm = 1'b1;

         phase_items = (p == PHASE_COUNT - 1) ? CALM_ITEMS : PHASE_ITEMS;
         for (k = 0; k < phase_items; k++)
            random_request(((k / RUN_LENGTH) % 2) == 0);
      end

      wait_idle();
      repeat (FLUSH_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && awaited_responses.size() == 0)
         $display("packed_field_array_insert_delete verification clean");
      else
         $display("packed_field_array_insert_delete verification failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Request driver. A word on offer is held until the block takes it; after
   // that the next pending request is offered, unless a random gap is due.
   // ------------------------------------------------------------------------
   int unsigned send_gap = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
      end else if (!(req_if.valid && !req_taken)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_if.valid <= 1'b0;
         end else if (!calm && $urandom_range(9) == 0) begin
            // This cycle opens a gap with no request on offer.
            send_gap = $urandom_range(7);
            req_if.valid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            req_if.valid   <= 1'b1;
            req_if.payload <= pending_requests[0].req;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response ready. A requested long hold is counted down here; otherwise
   // ready drops in random bursts.
   // ------------------------------------------------------------------------
   int unsigned hold_left   = 0;
   int unsigned hold_served = 0;
   int unsigned take_gap    = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left = 0;
         take_gap  = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES - 1;
         rsp_if.ready <= 1'b0;
      end else if (take_gap > 0) begin
         take_gap--;
         rsp_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(7) == 0) begin
         take_gap = $urandom_range(7);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor. Both channels are sampled at the rising edge. A response is
   // checked before the request of the same edge is recorded, so a response
   // can never be matched with a request taken at the same edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      op_record_type oldest, taken;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (awaited_responses.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: response word with no request outstanding:", $realtime,
                           " value %h status %0d count %0d",
                           rsp_if.payload.read_value, rsp_if.payload.status,
                           rsp_if.payload.element_count);
            end else begin
               oldest = awaited_responses.pop_front();
               if (rsp_if.payload.read_value !== oldest.rsp.read_value ||
                   rsp_if.payload.status !== oldest.rsp.status ||
                   rsp_if.payload.element_count !== oldest.rsp.element_count) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("%0t: mode %0d index %0d value %h:", $realtime,
                              oldest.req.mode, oldest.req.index, oldest.req.value,
                              " expected value %h status %0d count %0d,",
                              oldest.rsp.read_value, oldest.rsp.status,
                              oldest.rsp.element_count,
                              " got value %h status %0d count %0d",
                              rsp_if.payload.read_value, rsp_if.payload.status,
                              rsp_if.payload.element_count);
               end
            end
         end

         // The word just taken is always the front of the pending queue.
         req_taken = req_if.valid && req_if.ready;
         if (req_taken) begin
            taken = pending_requests.pop_front();
            awaited_responses.push_back(taken);
         end
      end
   end

   // Run limit, far above the slowest correct run.
   initial begin
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("packed_field_array_insert_delete verification failed");
      $finish;
   end

endmodule

[files.f]
rtl/core/pfa_pkg.sv
rtl/core/pfa_stream_if.sv
rtl/core/pfa_word_ram.sv
rtl/core/pfa_seq.sv
rtl/core/packed_field_array_insert_delete.sv
tb/tb_top.sv
